/* design/fpes_pkg.sv */
`timescale 1ns / 1ps
// widths, reset values, register indexes and state codes for the energy slicer
// no dependencies; imported by fixed_pitch_energy_slicer_top

package fpes_pkg;

    localparam int Z_W        = 32;
    localparam int E_W        = 24;
    localparam int OUT_W      = 25;
    localparam int PITCH_W    = 20;
    localparam int LIMIT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // plane position, step and offset widths
    localparam int NP_W = Z_W + 2;
    localparam int DZ_W = Z_W + 1;
    localparam int DE_W = E_W + 1;

    // bit-serial multiplier and divider
    localparam int MCAND_W  = Z_W;
    localparam int MPLIER_W = E_W;
    localparam int PROD_W   = MCAND_W + MPLIER_W;
    localparam int DVD_W    = PROD_W + 2;
    localparam int DVS_W    = Z_W + 1;
    localparam int SUM_W    = DVD_W + 2;
    localparam int CNT_W    = $clog2(DVD_W);

    localparam int MAX_SLICES_DEFAULT = 64;

    localparam logic [Z_W-1:0]     START_Z_RST = '0;
    localparam logic [PITCH_W-1:0] PITCH_RST   = PITCH_W'(490);
    localparam logic [LIMIT_W-1:0] LIMIT_RST   = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_Z = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_DUE_DIV,
        S_DUE_CAP,
        S_SL_START,
        S_SL_MUL,
        S_SL_LOAD,
        S_SL_DIV,
        S_SL_OUT,
        S_ADV_MUL,
        S_ADV
    } state_t;

endpackage

/* design/fixed_pitch_energy_slicer_top.sv */
`timescale 1ns / 1ps
// fixed-pitch energy slicer: interpolates track energy at evenly spaced planes
// one module with a bit-serial multiplier and restoring divider; uses fpes_pkg
//
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------------
// input    | in_valid / in_ready   | first_point, last_point, pos_z, kinetic_energy
// output   | out_valid / out_ready | slice_energy, last_of_run
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a point that yields no slice leaves the block idle and ready for the next one; a
// point that yields slices holds the input after its transfer while the bit-serial
// divider runs once for the slice count (skipped at zero pitch, where the slice count
// needs no division) and once per slice, and the shift-add multiplier runs once per
// slice and once for the plane step
// a full output register stalls the slice loop; results wait there while the
// next point is taken; reset is asynchronous and needs no clearing pass

module fixed_pitch_energy_slicer_top #(
    parameter int MAX_SLICES_PER_POINT = fpes_pkg::MAX_SLICES_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  first_point,
    input  logic                                  last_point,
    input  logic signed [fpes_pkg::Z_W-1:0]       pos_z,
    input  logic        [fpes_pkg::E_W-1:0]       kinetic_energy,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [fpes_pkg::OUT_W-1:0]     slice_energy,
    output logic                                  last_of_run,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [fpes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [fpes_pkg::CFG_DATA_W-1:0] cfg_data
);

    import fpes_pkg::*;

    localparam int KW = $clog2(MAX_SLICES_PER_POINT + 1);

    state_t state_reg, state_next;

    logic signed [Z_W-1:0]     start_reg, start_next;
    logic        [PITCH_W-1:0] pitch_reg, pitch_next;
    logic        [LIMIT_W-1:0] limit_reg, limit_next;

    logic signed [Z_W-1:0]     prev_z_reg, prev_z_next;
    logic        [E_W-1:0]     prev_e_reg, prev_e_next;
    logic signed [NP_W-1:0]    np_reg, np_next;
    logic        [LIMIT_W-1:0] count_reg, count_next;
    logic                      active_reg, active_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]   energy_reg, energy_next;
    logic                      last_reg, last_next;

    logic signed [Z_W-1:0]     cur_z_reg, cur_z_next;
    logic        [E_W-1:0]     cur_e_reg, cur_e_next;
    logic        [DZ_W-1:0]    dz_reg, dz_next;
    logic        [DE_W-1:0]    de_reg, de_next;
    logic        [NP_W-1:0]    off_reg, off_next;
    logic        [Z_W-1:0]     dz_abs_reg, dz_abs_next;
    logic        [E_W-1:0]     de_abs_reg, de_abs_next;
    logic                      sign_reg, sign_next;
    logic                      qneg_reg, qneg_next;
    logic        [LIMIT_W-1:0] due_reg, due_next;
    logic        [KW-1:0]      nemit_reg, nemit_next;
    logic        [KW-1:0]      k_reg, k_next;

    logic        [MCAND_W-1:0] mcand_reg, mcand_next;
    logic        [PROD_W-1:0]  prod_reg, prod_next;
    logic        [DVD_W-1:0]   dvd_reg, dvd_next;
    logic        [DVS_W-1:0]   rem_reg, rem_next;
    logic        [DVS_W-1:0]   dvs_reg, dvs_next;
    logic        [CNT_W-1:0]   cnt_reg, cnt_next;

    // serial datapath steps
    logic        [MCAND_W:0]   mul_sum;
    logic        [PROD_W-1:0]  mul_step;
    logic        [DVS_W:0]     div_trial;
    logic        [DVS_W:0]     div_diff;
    logic                      div_ge;
    logic        [DVS_W-1:0]   rem_step;
    logic        [DVD_W-1:0]   dvd_step;

    logic signed [NP_W-1:0]    pz_ext;
    logic signed [NP_W-1:0]    prev_ext;
    logic signed [NP_W-1:0]    cur_ext;
    logic                      is_source;
    logic        [DZ_W-1:0]    dz_mag;
    logic        [DE_W-1:0]    de_mag;
    logic        [NP_W-1:0]    off_mag;
    logic        [NP_W-1:0]    due_dvd;
    logic        [LIMIT_W-1:0] remaining;
    logic        [LIMIT_W-1:0] due_sel;
    logic signed [SUM_W-1:0]   interp;
    logic                      interp_fits;
    logic        [OUT_W-1:0]   energy_sat;
    logic                      slot_free;
    logic                      run_last;

    assign in_ready     = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign slice_energy = energy_reg;
    assign last_of_run  = last_reg;

    assign mul_sum   = {1'b0, prod_reg[PROD_W-1:MPLIER_W]}
                     + {1'b0, (prod_reg[0] ? mcand_reg : '0)};
    assign mul_step  = {mul_sum, prod_reg[MPLIER_W-1:1]};
    assign div_trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign div_diff  = div_trial - {1'b0, dvs_reg};
    assign div_ge    = (div_trial >= {1'b0, dvs_reg});
    assign rem_step  = div_ge ? div_diff[DVS_W-1:0] : div_trial[DVS_W-1:0];
    assign dvd_step  = {dvd_reg[DVD_W-2:0], div_ge};

    assign pz_ext    = {{(NP_W-Z_W){pos_z[Z_W-1]}}, pos_z};
    assign prev_ext  = {{(NP_W-Z_W){prev_z_reg[Z_W-1]}}, prev_z_reg};
    assign cur_ext   = {{(NP_W-Z_W){cur_z_reg[Z_W-1]}}, cur_z_reg};
    assign is_source = (pos_z >= start_reg) && (pos_z != prev_z_reg)
                     && (np_reg < pz_ext) && (count_reg < limit_reg);

    assign dz_mag  = dz_reg[DZ_W-1] ? (~dz_reg + 1'b1) : dz_reg;
    assign de_mag  = de_reg[DE_W-1] ? (~de_reg + 1'b1) : de_reg;
    assign off_mag = off_reg[NP_W-1] ? (~off_reg + 1'b1) : off_reg;
    assign due_dvd = cur_ext - np_reg + NP_W'(pitch_reg) - NP_W'(1);

    assign remaining = limit_reg - count_reg;
    always_comb
    begin
        priority if (pitch_reg == '0)
        begin
            due_sel = remaining;
        end
        else if ((|dvd_reg[DVD_W-1:LIMIT_W]) || (dvd_reg[LIMIT_W-1:0] > remaining))
        begin
            due_sel = remaining;
        end
        else
        begin
            due_sel = dvd_reg[LIMIT_W-1:0];
        end
    end

    // prev_energy minus the signed rounded quotient, then clamp
    assign interp = qneg_reg ? (SUM_W'(prev_e_reg) + SUM_W'(dvd_reg))
                             : (SUM_W'(prev_e_reg) - SUM_W'(dvd_reg));
    assign interp_fits = (&interp[SUM_W-1:OUT_W-1]) | ~(|interp[SUM_W-1:OUT_W-1]);
    assign energy_sat  = interp_fits ? interp[OUT_W-1:0]
                       : (interp[SUM_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                          : {1'b0, {(OUT_W-1){1'b1}}});

    assign slot_free = ~out_valid_reg | out_ready;
    assign run_last  = (k_reg == (nemit_reg - KW'(1)));

    always_comb
    begin
        state_next     = state_reg;
        start_next     = start_reg;
        pitch_next     = pitch_reg;
        limit_next     = limit_reg;
        prev_z_next    = prev_z_reg;
        prev_e_next    = prev_e_reg;
        np_next        = np_reg;
        count_next     = count_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        energy_next    = energy_reg;
        last_next      = last_reg;
        cur_z_next     = cur_z_reg;
        cur_e_next     = cur_e_reg;
        dz_next        = dz_reg;
        de_next        = de_reg;
        off_next       = off_reg;
        dz_abs_next    = dz_abs_reg;
        de_abs_next    = de_abs_reg;
        sign_next      = sign_reg;
        qneg_next      = qneg_reg;
        due_next       = due_reg;
        nemit_next     = nemit_reg;
        k_next         = k_reg;
        mcand_next     = mcand_reg;
        prod_next      = prod_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_Z: start_next = cfg_data[Z_W-1:0];
                CFG_PITCH:   pitch_next = cfg_data[PITCH_W-1:0];
                CFG_LIMIT:   limit_next = cfg_data[LIMIT_W-1:0];
                default:     ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cur_z_next = pos_z;
                    cur_e_next = kinetic_energy;
                    dz_next    = pz_ext[DZ_W-1:0] - prev_ext[DZ_W-1:0];
                    de_next    = {1'b0, prev_e_reg} - {1'b0, kinetic_energy};
                    off_next   = np_reg - prev_ext;
                    priority if (first_point)
                    begin
                        prev_z_next = pos_z;
                        prev_e_next = kinetic_energy;
                        np_next     = {{(NP_W-Z_W){start_reg[Z_W-1]}}, start_reg};
                        count_next  = '0;
                        active_next = ~last_point;
                    end
                    else if (!active_reg)
                    begin
                        active_next = 1'b0;
                    end
                    else if (last_point)
                    begin
                        active_next = 1'b0;
                    end
                    else if (is_source)
                    begin
                        state_next = S_SETUP;
                    end
                    else
                    begin
                        prev_z_next = pos_z;
                        prev_e_next = kinetic_energy;
                    end
                end
            end

            S_SETUP:
            begin
                dz_abs_next = dz_mag[Z_W-1:0];
                de_abs_next = de_mag[E_W-1:0];
                sign_next   = dz_reg[DZ_W-1] ^ de_reg[DE_W-1];
                dvd_next    = DVD_W'(due_dvd);
                rem_next    = '0;
                dvs_next    = DVS_W'(pitch_reg);
                cnt_next    = '0;
                state_next  = (pitch_reg == '0) ? S_DUE_CAP : S_DUE_DIV;
            end

            S_DUE_DIV:
            begin
                dvd_next = dvd_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    state_next = S_DUE_CAP;
                end
            end

            S_DUE_CAP:
            begin
                due_next   = due_sel;
                nemit_next = (due_sel > LIMIT_W'(MAX_SLICES_PER_POINT))
                           ? KW'(MAX_SLICES_PER_POINT) : due_sel[KW-1:0];
                k_next     = '0;
                state_next = S_SL_START;
            end

            S_SL_START:
            begin
                mcand_next = off_mag[MCAND_W-1:0];
                prod_next  = PROD_W'(de_abs_reg);
                qneg_next  = sign_reg ^ off_reg[NP_W-1];
                cnt_next   = '0;
                state_next = S_SL_MUL;
            end

            S_SL_MUL:
            begin
                prod_next = mul_step;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MPLIER_W - 1))
                begin
                    state_next = S_SL_LOAD;
                end
            end

            S_SL_LOAD:
            begin
                dvd_next   = DVD_W'({prod_reg, 1'b0}) + DVD_W'(dz_abs_reg);
                rem_next   = '0;
                dvs_next   = {dz_abs_reg, 1'b0};
                cnt_next   = '0;
                state_next = S_SL_DIV;
            end

            S_SL_DIV:
            begin
                dvd_next = dvd_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    state_next = S_SL_OUT;
                end
            end

            S_SL_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    energy_next    = energy_sat;
                    last_next      = run_last;
                    off_next       = off_reg + NP_W'(pitch_reg);
                    k_next         = k_reg + 1'b1;
                    if (run_last)
                    begin
                        mcand_next = MCAND_W'(due_reg);
                        prod_next  = PROD_W'(pitch_reg);
                        cnt_next   = '0;
                        state_next = S_ADV_MUL;
                    end
                    else
                    begin
                        state_next = S_SL_START;
                    end
                end
            end

            S_ADV_MUL:
            begin
                prod_next = mul_step;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MPLIER_W - 1))
                begin
                    state_next = S_ADV;
                end
            end

            S_ADV:
            begin
                np_next     = np_reg + prod_reg[NP_W-1:0];
                count_next  = count_reg + due_reg;
                prev_z_next = cur_z_reg;
                prev_e_next = cur_e_reg;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= START_Z_RST;
            pitch_reg     <= PITCH_RST;
            limit_reg     <= LIMIT_RST;
            prev_z_reg    <= '0;
            prev_e_reg    <= '0;
            np_reg        <= '0;
            count_reg     <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            pitch_reg     <= pitch_next;
            limit_reg     <= limit_next;
            prev_z_reg    <= prev_z_next;
            prev_e_reg    <= prev_e_next;
            np_reg        <= np_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        energy_reg <= energy_next;
        last_reg   <= last_next;
        cur_z_reg  <= cur_z_next;
        cur_e_reg  <= cur_e_next;
        dz_reg     <= dz_next;
        de_reg     <= de_next;
        off_reg    <= off_next;
        dz_abs_reg <= dz_abs_next;
        de_abs_reg <= de_abs_next;
        sign_reg   <= sign_next;
        qneg_reg   <= qneg_next;
        due_reg    <= due_next;
        nemit_reg  <= nemit_next;
        k_reg      <= k_next;
        mcand_reg  <= mcand_next;
        prod_reg   <= prod_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        cnt_reg    <= cnt_next;
    end

endmodule
